@@ design/odeque_pkg.sv @@
// Shared types and codes for the bounded deque with positional insert.
`timescale 1ns / 1ps
`default_nettype none

package odeque_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;
	typedef logic signed [15:0] elem_t;

	localparam kind_t KIND_PUSH = 2'd0;
	localparam kind_t KIND_POP  = 2'd1;
	localparam kind_t KIND_ENQ  = 2'd2;
	localparam kind_t KIND_INS  = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam elem_t EMPTY_VALUE = -16'sd1;

endpackage

`default_nettype wire

@@ design/ordered_list_deque_with_insert.sv @@
// Top level of the bounded deque with positional insert.
//
// The request channel (req_valid, req_stall) carries kind, value and position.
// The response channel (rsp_valid, rsp_stall) returns popped_value, status and
// count, exactly one response transfer per request transfer, in order.
// A request is taken only while the sequencer is idle; req_stall is high for
// the whole time an operation is being worked on.
// Elements live in a single-port-write, registered-read memory, and a small
// sequencer moves them one at a time through that port: each move is a read
// step followed by a write step. A pop of an empty list or an add to a full
// list skips the moves and goes straight to the finish step.
// The response sits in an output register, so a new request is taken while an
// earlier response is still stalled; the sequencer waits at the end of the
// next operation until that register is free.
// After reset the list is empty and no response is pending. Memory contents
// are not cleared; only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_deque_with_insert #(
	parameter int DEPTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	input  wire odeque_pkg::kind_t kind,
	input  wire odeque_pkg::elem_t value,
	input  wire  [4:0]             position,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output odeque_pkg::elem_t      popped_value,
	output odeque_pkg::status_t    status,
	output logic [4:0]             count
);

	import odeque_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HEAD  = 3'd1;
	localparam logic [2:0] S_HEADW = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_WR    = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] idx_q;
	logic          dir_pop_q;
	elem_t         value_q;
	elem_t         res_pop_q;
	status_t       res_status_q;

	elem_t         mem_q [DEPTH];
	elem_t         rdata_q;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	elem_t         mem_wdata;
	logic          mem_we;

	logic          req_take;
	logic          rsp_free;
	logic [CW-1:0] ptr_inc;
	logic [CW-1:0] ptr_dec;
	logic [CW-1:0] src_ptr;
	logic [CW-1:0] dst_ptr;
	logic          more;
	logic [CW-1:0] ins_idx;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid || !rsp_stall;

	// Shared step unit: one element move per loop pass, toward the head on a
	// pop and toward the tail on an add.
	assign ptr_inc = ptr_q + CNT_ONE;
	assign ptr_dec = ptr_q - CNT_ONE;
	assign src_ptr = dir_pop_q ? ptr_q : ptr_dec;
	assign dst_ptr = dir_pop_q ? ptr_dec : ptr_q;
	assign more    = dir_pop_q ? (ptr_q < cnt_q) : (ptr_q > idx_q);

	always_comb begin
		unique case (kind)
			KIND_PUSH: ins_idx = '0;
			KIND_ENQ:  ins_idx = cnt_q;
			default: begin
				if (PW'(position) > PW'(cnt_q)) begin
					ins_idx = cnt_q;
				end else begin
					ins_idx = CW'(position);
				end
			end
		endcase
	end

	always_comb begin
		mem_raddr = AW'(src_ptr);
		mem_waddr = AW'(dst_ptr);
		mem_wdata = rdata_q;
		mem_we    = 1'b0;
		unique case (state_q)
			S_HEAD: begin
				mem_raddr = '0;
			end
			S_WR: begin
				mem_we = 1'b1;
			end
			S_RD: begin
				if (!more && !dir_pop_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(idx_q);
					mem_wdata = value_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			idx_q        <= '0;
			dir_pop_q    <= 1'b0;
			rsp_valid    <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			// In the finish step the output register is reloaded rather than cleared.
			if (rsp_valid && !rsp_stall && state_q != S_FIN) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						value_q      <= value;
						res_pop_q    <= '0;
						res_status_q <= ST_OK;
						if (kind == KIND_POP) begin
							dir_pop_q <= 1'b1;
							if (cnt_q == '0) begin
								res_pop_q    <= EMPTY_VALUE;
								res_status_q <= ST_EMPTY;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_HEAD;
							end
						end else begin
							dir_pop_q <= 1'b0;
							if (cnt_q == CNT_MAX) begin
								res_status_q <= ST_FULL;
								state_q      <= S_FIN;
							end else begin
								idx_q   <= ins_idx;
								ptr_q   <= cnt_q;
								state_q <= S_RD;
							end
						end
					end
				end
				S_HEAD: begin
					state_q <= S_HEADW;
				end
				S_HEADW: begin
					res_pop_q <= rdata_q;
					ptr_q     <= CNT_ONE;
					state_q   <= S_RD;
				end
				S_RD: begin
					if (more) begin
						state_q <= S_WR;
					end else begin
						cnt_q   <= dir_pop_q ? (cnt_q - CNT_ONE) : (cnt_q + CNT_ONE);
						state_q <= S_FIN;
					end
				end
				S_WR: begin
					ptr_q   <= dir_pop_q ? ptr_inc : ptr_dec;
					state_q <= S_RD;
				end
				S_FIN: begin
					if (rsp_free) begin
						popped_value <= res_pop_q;
						status       <= res_status_q;
						count        <= 5'(cnt_q);
						rsp_valid    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("element count exceeds depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_WR) |-> ptr_q <= cnt_q)
		else $error("move pointer beyond element count");

	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == S_FIN)
		else $error("response raised outside the finish step");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_EMPTY) |-> popped_value == EMPTY_VALUE)
		else $error("empty pop without the empty marker value");

endmodule

`default_nettype wire

@@ tb/sv/tb_ordered_list_deque_with_insert.sv @@
// Self-checking testbench for the bounded deque with positional insert.
`timescale 1ns / 1ps

module tb_ordered_list_deque_with_insert;
	import odeque_pkg::*;

	localparam int DEPTH       = 16;
	localparam int LONG_HOLD   = 250;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP   = 50;

	typedef struct {
		elem_t      popped;
		status_t    st;
		logic [4:0] cnt;
	} list_outcome_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       req_valid    = 1'b0;
	logic       req_stall;
	kind_t      kind         = KIND_PUSH;
	elem_t      value        = '0;
	logic [4:0] position     = '0;
	logic       rsp_valid;
	logic       rsp_stall    = 1'b0;
	elem_t      popped_value;
	status_t    status;
	logic [4:0] count;

	// Mirror of the list contents and the outcomes still owed by the block.
	elem_t         mirror_list[$];
	list_outcome_t pending_outcomes[$];

	int send_idle_pct    = 0;
	int rsp_idle_pct     = 0;
	int hold_gen         = 0;
	int hold_seen        = 0;
	int hold_left        = 0;
	int cycle_count      = 0;
	int mismatches       = 0;
	int ops_sent         = 0;
	int outcomes_checked = 0;
	int full_drops       = 0;
	int empty_pops       = 0;

	ordered_list_deque_with_insert #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.value(value),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.popped_value(popped_value),
		.status(status),
		.count(count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_count, pending_outcomes.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Applies one operation to the mirror list and returns what the block must answer.
	function automatic list_outcome_t list_op_outcome(kind_t k, elem_t v, logic [4:0] p);
		list_outcome_t r;
		int            idx;
		r.popped = '0;
		r.st     = ST_OK;
		if (k == KIND_POP) begin
			if (mirror_list.size() == 0) begin
				r.popped = EMPTY_VALUE;
				r.st     = ST_EMPTY;
				empty_pops++;
			end else begin
				r.popped = mirror_list.pop_front();
			end
		end else if (mirror_list.size() >= DEPTH) begin
			r.st = ST_FULL;
			full_drops++;
		end else if (k == KIND_PUSH) begin
			mirror_list.push_front(v);
		end else if (k == KIND_ENQ) begin
			mirror_list.push_back(v);
		end else begin
			idx = (int'(p) > mirror_list.size()) ? mirror_list.size() : int'(p);
			mirror_list.insert(idx, v);
		end
		r.cnt = 5'(mirror_list.size());
		return r;
	endfunction

	function automatic kind_t random_add_kind();
		case ($urandom_range(2))
			0: return KIND_PUSH;
			1: return KIND_ENQ;
			default: return KIND_INS;
		endcase
	endfunction

	function automatic elem_t random_value();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return EMPTY_VALUE;
			3: return '0;
			default: return elem_t'($urandom);
		endcase
	endfunction

	// Mostly a valid index, sometimes anything the field can hold.
	function automatic logic [4:0] random_position();
		if ($urandom_range(3) == 0)
			return 5'($urandom_range(31));
		return 5'($urandom_range(mirror_list.size()));
	endfunction

	task automatic report_mismatch(input string msg);
		// Printing is capped so a badly broken block does not flood the log.
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Returns at the edge where the transfer happened, with req_valid still high.
	task automatic send_op(input kind_t k, input elem_t v, input logic [4:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		value     <= v;
		position  <= p;
		do
			@(posedge clk);
		while (req_stall);
		pending_outcomes.push_back(list_op_outcome(k, v, p));
		ops_sent++;
	endtask

	task automatic wait_for_outcomes();
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_gen != hold_seen) begin
			hold_seen = hold_gen;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	always @(posedge clk) begin : check_outcomes
		list_outcome_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("response with none expected: popped %0d status %0d count %0d",
					popped_value, status, count));
			end else begin
				want = pending_outcomes.pop_front();
				if (popped_value !== want.popped)
					report_mismatch($sformatf("response %0d popped_value got %0d expected %0d",
						outcomes_checked, popped_value, want.popped));
				if (status !== want.st)
					report_mismatch($sformatf("response %0d status got %0d expected %0d",
						outcomes_checked, status, want.st));
				if (count !== want.cnt)
					report_mismatch($sformatf("response %0d count got %0d expected %0d",
						outcomes_checked, count, want.cnt));
			end
			outcomes_checked++;
		end
	end

	// Extreme values, every operation, clamped and head-position inserts, and the empty pop.
	task automatic test_directed();
		send_idle_pct = 0;
		rsp_idle_pct  = 0;
		send_op(KIND_POP, '0, 5'd0);
		send_op(KIND_INS, 16'sh7FFF, 5'd5);
		send_op(KIND_PUSH, -16'sh8000, 5'd31);
		send_op(KIND_ENQ, '0, 5'd0);
		send_op(KIND_INS, EMPTY_VALUE, 5'd0);
		send_op(KIND_INS, 16'sh5555, 5'd31);
		send_op(KIND_INS, elem_t'(16'hAAAA), 5'd2);
		send_op(KIND_INS, 16'sh0001, 5'd16);
		send_op(KIND_INS, 16'sh1234, 5'd8);
		send_op(KIND_ENQ, elem_t'(16'hFFFE), 5'd21);
		send_op(KIND_PUSH, 16'sh4000, 5'd10);
		repeat (11)
			send_op(KIND_POP, elem_t'(16'hFFFF), 5'd31);
		wait_for_outcomes();
	endtask

	// Fills the list with random adds, hits the full drop with each add kind, empties it, then pops it once empty.
	task automatic test_full_list();
		send_idle_pct = 35;
		rsp_idle_pct  = 54;
		while (mirror_list.size() < DEPTH)
			send_op(random_add_kind(), random_value(), random_position());
		send_op(KIND_PUSH, random_value(), random_position());
		send_op(KIND_ENQ, random_value(), random_position());
		send_op(KIND_INS, random_value(), random_position());
		while (mirror_list.size() > 0)
			send_op(KIND_POP, random_value(), random_position());
		send_op(KIND_POP, random_value(), random_position());
		wait_for_outcomes();
	endtask

	// Random operations whose mix drifts between filling and draining, so the
	// count sweeps its whole range.
	task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
		int    i;
		bit    filling;
		kind_t k;
		send_idle_pct = send_pct;
		rsp_idle_pct  = recv_pct;
		filling = 1'b1;
		for (i = 0; i < n_items; i++) begin
			if (mirror_list.size() == DEPTH && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (mirror_list.size() == 0 && $urandom_range(3) == 0)
				filling = 1'b1;
			else if ($urandom_range(24) == 0)
				filling = !filling;
			if ($urandom_range(99) < (filling ? 20 : 70))
				k = KIND_POP;
			else
				k = random_add_kind();
			send_op(k, random_value(), random_position());
		end
		wait_for_outcomes();
	endtask

	// The receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		rsp_idle_pct  = 0;
		hold_gen <= hold_gen + 1;
		for (i = 0; i < 10; i++)
			send_op(($urandom_range(2) == 0) ? KIND_POP : random_add_kind(),
				random_value(), random_position());
		wait_for_outcomes();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		test_random(120, 35, 54);
		test_backpressure();
		test_random(120, 54, 35);
		test_random(120, 0, 0);
		wait_for_outcomes();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d operations and checked %0d responses in %0d cycles.",
			ops_sent, outcomes_checked, cycle_count);
		$display("Saw %0d adds dropped on a full list and %0d pops of an empty list.",
			full_drops, empty_pops);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches,
				pending_outcomes.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
